>>> src/textured_pixel_blend_composite_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the textured pixel blend compositor
// Shared property wrappers for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_PIXEL_BLEND_COMPOSITE_ASSERT_SVH
`define TEXTURED_PIXEL_BLEND_COMPOSITE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TPBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define TPBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tpbc_pkg.sv
// ----------------------------------------------------------------------------
// tpbc_pkg
// Types, constants and functions shared by the compositor pipeline.
// ----------------------------------------------------------------------------
package tpbc_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int PM_LAT   = 4;
    localparam int FLT_LAT  = 3;
    localparam int BLD_LAT  = 2;
    localparam int DIV_LAT  = 9;
    localparam int PIPE_LAT = PM_LAT + FLT_LAT + BLD_LAT + DIV_LAT + 1;

    localparam logic [2:0] CFG_FACTOR_KINDS = 3'd0;
    localparam logic [2:0] CFG_CLAMP_SUMS   = 3'd1;
    localparam logic [2:0] CFG_FILTER_MODE  = 3'd2;
    localparam logic [2:0] CFG_SCALE_RED    = 3'd3;
    localparam logic [2:0] CFG_SCALE_GREEN  = 3'd4;
    localparam logic [2:0] CFG_SCALE_BLUE   = 3'd5;
    localparam logic [2:0] CFG_SCALE_ALPHA  = 3'd6;

    localparam logic [15:0] KINDS_RESET = 16'h5511;
    localparam logic [15:0] SCALE_RESET = 16'd4096;

    localparam logic [3:0] KIND_ZERO     = 4'd0;
    localparam logic [3:0] KIND_ONE      = 4'd1;
    localparam logic [3:0] KIND_SC       = 4'd2;
    localparam logic [3:0] KIND_ONE_M_SC = 4'd3;
    localparam logic [3:0] KIND_SA       = 4'd4;
    localparam logic [3:0] KIND_ONE_M_SA = 4'd5;
    localparam logic [3:0] KIND_DC       = 4'd6;
    localparam logic [3:0] KIND_ONE_M_DC = 4'd7;
    localparam logic [3:0] KIND_DA       = 4'd8;
    localparam logic [3:0] KIND_ONE_M_DA = 4'd9;

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [15:0] DIV_PREMUL = 16'd65025;
    localparam logic [24:0] RECIP_PREMUL = 25'((64'd1 << 40) / 64'd65025);

    typedef logic [3:0][16:0] t_q16px;
    typedef logic [3:0][20:0] t_smp;
    typedef logic [3:0][15:0] t_scales;
    typedef logic [2:0][29:0] t_sums;

    typedef struct packed {
        logic [15:0] kinds;
        logic        clamp;
    } t_blend_cfg;

    function automatic logic signed [22:0] blend_factor(
        input logic [3:0]  kind,
        input logic [20:0] sc,
        input logic [20:0] sa,
        input logic [20:0] dc,
        input logic [20:0] da
    );
        logic signed [22:0] one;
        logic signed [22:0] f;
        one = 23'sd65536;
        case (kind)
            KIND_ONE:      f = one;
            KIND_SC:       f = $signed({2'b00, sc});
            KIND_ONE_M_SC: f = one - $signed({2'b00, sc});
            KIND_SA:       f = $signed({2'b00, sa});
            KIND_ONE_M_SA: f = one - $signed({2'b00, sa});
            KIND_DC:       f = $signed({2'b00, dc});
            KIND_ONE_M_DC: f = one - $signed({2'b00, dc});
            KIND_DA:       f = $signed({2'b00, da});
            KIND_ONE_M_DA: f = one - $signed({2'b00, da});
            default:       f = '0;
        endcase
        return f;
    endfunction

endpackage

>>> src/tpbc_premul.sv
// ----------------------------------------------------------------------------
// tpbc_premul
// Converts a straight RGBA8 pixel to premultiplied Q16 channels.
// ----------------------------------------------------------------------------
module tpbc_premul (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_pixel,
    output tpbc_pkg::t_q16px o_premul
);
    import tpbc_pkg::*;

    logic [2:0][15:0] r_s1_p;
    logic [16:0]      r_s1_a;
    logic [2:0][31:0] r_s2_x;
    logic [2:0][16:0] r_s2_q0;
    logic [16:0]      r_s2_a;
    logic [2:0][31:0] r_s3_x;
    logic [2:0][16:0] r_s3_q0;
    logic [2:0][32:0] r_s3_m;
    logic [16:0]      r_s3_a;
    t_q16px           r_s4_t;

    logic [2:0][15:0] n_s1_p;
    logic [16:0]      n_s1_a;
    logic [2:0][31:0] n_s2_x;
    logic [2:0][16:0] n_s2_q0;
    logic [2:0][32:0] n_s3_m;
    t_q16px           n_s4_t;

    always_comb begin
        logic [7:0]  a;
        logic [56:0] prod;
        logic [32:0] rem;
        a = i_pixel[31:24];
        n_s1_a = 17'(a) * 17'd257 + 17'(a[7]);
        for (int k = 0; k < 3; k++) begin
            n_s1_p[k] = {8'd0, i_pixel[8*k +: 8]} * {8'd0, a};
        end
        for (int k = 0; k < 3; k++) begin
            n_s2_x[k]  = {r_s1_p[k], 16'd32512};
            prod       = 57'(n_s2_x[k]) * 57'(RECIP_PREMUL);
            n_s2_q0[k] = prod[56:40];
        end
        for (int k = 0; k < 3; k++) begin
            n_s3_m[k] = 33'(r_s2_q0[k]) * 33'(DIV_PREMUL);
        end
        for (int k = 0; k < 3; k++) begin
            rem       = {1'b0, r_s3_x[k]} - r_s3_m[k];
            n_s4_t[k] = r_s3_q0[k] + 17'(rem >= 33'(DIV_PREMUL));
        end
        n_s4_t[3] = r_s3_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_p  <= n_s1_p;
            r_s1_a  <= n_s1_a;
            r_s2_x  <= n_s2_x;
            r_s2_q0 <= n_s2_q0;
            r_s2_a  <= r_s1_a;
            r_s3_x  <= r_s2_x;
            r_s3_q0 <= r_s2_q0;
            r_s3_m  <= n_s3_m;
            r_s3_a  <= r_s2_a;
            r_s4_t  <= n_s4_t;
        end
    end

    assign o_premul = r_s4_t;

endmodule

>>> src/tpbc_filter.sv
// ----------------------------------------------------------------------------
// tpbc_filter
// Bilinear or nearest sampling of four texels, then per-channel scaling.
// ----------------------------------------------------------------------------
module tpbc_filter #(
    parameter int FRAC_BITS = tpbc_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tpbc_pkg::t_q16px     i_t00,
    input  tpbc_pkg::t_q16px     i_t10,
    input  tpbc_pkg::t_q16px     i_t01,
    input  tpbc_pkg::t_q16px     i_t11,
    input  logic [FRAC_BITS-1:0] i_fu,
    input  logic [FRAC_BITS-1:0] i_fv,
    input  logic                 i_bilinear,
    input  tpbc_pkg::t_scales    i_scales,
    output tpbc_pkg::t_smp       o_sample
);
    import tpbc_pkg::*;

    localparam int ACC_W = 17 + FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] FULL = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic [16:0] lerp(
        input logic [16:0]          p,
        input logic [16:0]          q,
        input logic [FRAC_BITS-1:0] w
    );
        logic [FRAC_BITS:0] wc;
        logic [ACC_W-1:0]   acc;
        wc  = FULL - {1'b0, w};
        acc = ACC_W'(p) * ACC_W'(wc) + ACC_W'(q) * ACC_W'(w) + ACC_W'(FULL >> 1);
        return acc[FRAC_BITS +: 17];
    endfunction

    t_q16px               r_top;
    t_q16px               r_bot;
    t_q16px               r_near;
    logic [FRAC_BITS-1:0] r_fv;
    t_q16px               r_smp;
    t_smp                 r_scaled;

    t_q16px n_top;
    t_q16px n_bot;
    t_q16px n_smp;
    t_smp   n_scaled;

    always_comb begin
        logic [32:0] prod;
        for (int k = 0; k < 4; k++) begin
            n_top[k] = lerp(i_t00[k], i_t10[k], i_fu);
            n_bot[k] = lerp(i_t01[k], i_t11[k], i_fu);
            n_smp[k] = i_bilinear ? lerp(r_top[k], r_bot[k], r_fv) : r_near[k];
        end
        for (int k = 0; k < 4; k++) begin
            prod        = 33'(r_smp[k]) * 33'(i_scales[k]) + 33'd2048;
            n_scaled[k] = prod[32:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top    <= n_top;
            r_bot    <= n_bot;
            r_near   <= i_t00;
            r_fv     <= i_fv;
            r_smp    <= n_smp;
            r_scaled <= n_scaled;
        end
    end

    assign o_sample = r_scaled;

endmodule

>>> src/tpbc_blend.sv
// ----------------------------------------------------------------------------
// tpbc_blend
// Source and destination factor blend, optional clamp, output alpha select.
// ----------------------------------------------------------------------------
module tpbc_blend (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tpbc_pkg::t_smp       i_s,
    input  tpbc_pkg::t_q16px     i_d,
    input  tpbc_pkg::t_blend_cfg i_cfg,
    output tpbc_pkg::t_sums      o_sum,
    output logic [16:0]          o_oa,
    output logic                 o_alpha_zero
);
    import tpbc_pkg::*;

    logic [3:0][44:0] r_ps;
    logic [3:0][44:0] r_pd;
    t_sums            r_sum;
    logic [16:0]      r_oa;
    logic             r_az;

    logic [3:0][44:0] n_ps;
    logic [3:0][44:0] n_pd;
    t_sums            n_sum;
    logic [16:0]      n_oa;
    logic             n_az;

    always_comb begin
        logic signed [22:0] fs;
        logic signed [22:0] fd;
        logic [20:0]        dc;
        logic [20:0]        da;
        logic signed [29:0] o [0:3];
        da = 21'(i_d[3]);
        for (int k = 0; k < 4; k++) begin
            dc = 21'(i_d[k]);
            if (k < 3) begin
                fs = blend_factor(i_cfg.kinds[3:0], i_s[k], i_s[3], dc, da);
                fd = blend_factor(i_cfg.kinds[11:8], i_s[k], i_s[3], dc, da);
            end else begin
                fs = blend_factor(i_cfg.kinds[7:4], i_s[3], i_s[3], da, da);
                fd = blend_factor(i_cfg.kinds[15:12], i_s[3], i_s[3], da, da);
            end
            n_ps[k] = 45'($signed({1'b0, i_s[k]})) * 45'(fs);
            n_pd[k] = 45'($signed({1'b0, i_d[k]})) * 45'(fd);
        end
        for (int k = 0; k < 4; k++) begin
            o[k] = 30'(($signed(r_ps[k]) + 45'sd32768) >>> 16)
                 + 30'(($signed(r_pd[k]) + 45'sd32768) >>> 16);
            if (i_cfg.clamp) begin
                if (o[k] < 0) begin
                    o[k] = '0;
                end else if (o[k] > 30'sd65536) begin
                    o[k] = 30'sd65536;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = o[k];
        end
        n_az = (o[3] <= 0);
        if (n_az) begin
            n_oa = 17'd1;
        end else if (o[3] > 30'sd65536) begin
            n_oa = Q16_ONE;
        end else begin
            n_oa = o[3][16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ps  <= n_ps;
            r_pd  <= n_pd;
            r_sum <= n_sum;
            r_oa  <= n_oa;
            r_az  <= n_az;
        end
    end

    assign o_sum        = r_sum;
    assign o_oa         = r_oa;
    assign o_alpha_zero = r_az;

endmodule

>>> src/tpbc_div.sv
// ----------------------------------------------------------------------------
// tpbc_div
// Pipelined restoring divider that unpremultiplies one colour to a byte.
// ----------------------------------------------------------------------------
module tpbc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_sum,
    input  logic [16:0] i_oa,
    output logic [7:0]  o_byte
);
    import tpbc_pkg::*;

    localparam int STEPS = DIV_LAT - 1;

    logic [24:0]      r_rem  [0:STEPS];
    logic [17:0]      r_den  [0:STEPS];
    logic [STEPS-1:0] r_quo  [0:STEPS];
    logic             r_zero [0:STEPS];
    logic             r_sat  [0:STEPS];

    logic [24:0]      n_rem [0:STEPS];
    logic [STEPS-1:0] n_quo [0:STEPS];
    logic             n_zero;
    logic             n_sat;

    always_comb begin
        logic [38:0] num;
        logic [24:0] sub;
        logic        take;
        num    = 39'(i_sum[28:0]) * 39'd510 + 39'(i_oa);
        n_zero = i_sum[29] || (i_sum == '0);
        n_sat  = !n_zero && (num >= (39'(i_oa) << 9));
        n_rem[0] = (n_zero || n_sat) ? '0 : num[24:0];
        n_quo[0] = '0;
        for (int k = 0; k < STEPS; k++) begin
            sub  = 25'(r_den[k]) << (STEPS - 1 - k);
            take = (r_rem[k] >= sub);
            n_rem[k+1] = take ? r_rem[k] - sub : r_rem[k];
            n_quo[k+1] = r_quo[k];
            n_quo[k+1][STEPS-1-k] = take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem[0];
            r_quo[0]  <= n_quo[0];
            r_den[0]  <= {i_oa, 1'b0};
            r_zero[0] <= n_zero;
            r_sat[0]  <= n_sat;
            for (int k = 0; k < STEPS; k++) begin
                r_rem[k+1]  <= n_rem[k+1];
                r_quo[k+1]  <= n_quo[k+1];
                r_den[k+1]  <= r_den[k];
                r_zero[k+1] <= r_zero[k];
                r_sat[k+1]  <= r_sat[k];
            end
        end
    end

    assign o_byte = r_zero[STEPS] ? 8'd0 : (r_sat[STEPS] ? 8'hff : 8'(r_quo[STEPS]));

endmodule

>>> src/textured_pixel_blend_composite.sv
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// The depth is set by the premultiply divide, the bilinear lerps, the factor blend and the 8-step divider.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// textured_pixel_blend_composite
// Textured sample premultiply, filter, scale, factor blend and unpremultiply.
// ----------------------------------------------------------------------------
`include "textured_pixel_blend_composite_assert.svh"

module textured_pixel_blend_composite #(
    parameter int FRAC_BITS = tpbc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_covered,
    input  logic [31:0] i_texel_top_left,
    input  logic [31:0] i_texel_top_right,
    input  logic [31:0] i_texel_bottom_left,
    input  logic [31:0] i_texel_bottom_right,
    input  logic [7:0]  i_frac_u,
    input  logic [7:0]  i_frac_v,
    input  logic [31:0] i_dst_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_out,
    output logic        o_was_written
);
    import tpbc_pkg::*;

    localparam int SIDE_LAT = PIPE_LAT - 1;

    logic [15:0] r_kinds;
    logic        r_clamp;
    logic        r_bilinear;
    t_scales     r_scales;

    logic [PIPE_LAT-1:0]  r_vld;
    logic                 r_cov [0:SIDE_LAT-1];
    logic [31:0]          r_dst [0:SIDE_LAT-1];
    logic [FRAC_BITS-1:0] r_fu  [0:PM_LAT-1];
    logic [FRAC_BITS-1:0] r_fv  [0:PM_LAT-1];
    t_q16px               r_dpm [0:FLT_LAT-1];
    logic [7:0]           r_abyte [0:DIV_LAT-1];
    logic                 r_az    [0:DIV_LAT-1];
    logic [31:0]          r_pixel;
    logic                 r_written;

    logic       adv;
    t_q16px     pm_tl;
    t_q16px     pm_tr;
    t_q16px     pm_bl;
    t_q16px     pm_br;
    t_q16px     pm_dst;
    t_smp       smp;
    t_blend_cfg bcfg;
    t_sums      sums;
    logic [16:0] oa;
    logic        az;
    logic [7:0]  n_abyte;
    logic [24:0] aprod;
    logic [2:0][7:0] cbyte;
    logic [31:0] n_pixel;

    assign adv     = !(r_vld[PIPE_LAT-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kinds    <= KINDS_RESET;
            r_clamp    <= 1'b0;
            r_bilinear <= 1'b0;
            r_scales   <= {4{SCALE_RESET}};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FACTOR_KINDS: r_kinds     <= i_cfg_data;
                CFG_CLAMP_SUMS:   r_clamp     <= i_cfg_data[0];
                CFG_FILTER_MODE:  r_bilinear  <= i_cfg_data[0];
                CFG_SCALE_RED:    r_scales[0] <= i_cfg_data;
                CFG_SCALE_GREEN:  r_scales[1] <= i_cfg_data;
                CFG_SCALE_BLUE:   r_scales[2] <= i_cfg_data;
                CFG_SCALE_ALPHA:  r_scales[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    tpbc_premul u_pm_tl (.i_clk(i_clk), .i_en(adv), .i_pixel(i_texel_top_left),
                         .o_premul(pm_tl));
    tpbc_premul u_pm_tr (.i_clk(i_clk), .i_en(adv), .i_pixel(i_texel_top_right),
                         .o_premul(pm_tr));
    tpbc_premul u_pm_bl (.i_clk(i_clk), .i_en(adv), .i_pixel(i_texel_bottom_left),
                         .o_premul(pm_bl));
    tpbc_premul u_pm_br (.i_clk(i_clk), .i_en(adv), .i_pixel(i_texel_bottom_right),
                         .o_premul(pm_br));
    tpbc_premul u_pm_dst (.i_clk(i_clk), .i_en(adv), .i_pixel(i_dst_pixel),
                          .o_premul(pm_dst));

    tpbc_filter #(.FRAC_BITS(FRAC_BITS)) u_filter (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_t00      (pm_tl),
        .i_t10      (pm_tr),
        .i_t01      (pm_bl),
        .i_t11      (pm_br),
        .i_fu       (r_fu[PM_LAT-1]),
        .i_fv       (r_fv[PM_LAT-1]),
        .i_bilinear (r_bilinear),
        .i_scales   (r_scales),
        .o_sample   (smp)
    );

    assign bcfg.kinds = r_kinds;
    assign bcfg.clamp = r_clamp;

    tpbc_blend u_blend (
        .i_clk        (i_clk),
        .i_en         (adv),
        .i_s          (smp),
        .i_d          (r_dpm[FLT_LAT-1]),
        .i_cfg        (bcfg),
        .o_sum        (sums),
        .o_oa         (oa),
        .o_alpha_zero (az)
    );

    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++) begin : g_div
            tpbc_div u_div (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_sum  (sums[gc]),
                .i_oa   (oa),
                .o_byte (cbyte[gc])
            );
        end
    endgenerate

    assign aprod   = 25'(oa) * 25'd255 + 25'd32768;
    assign n_abyte = aprod[23:16];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cov[0] <= i_covered;
            r_dst[0] <= i_dst_pixel;
            for (int k = 1; k < SIDE_LAT; k++) begin
                r_cov[k] <= r_cov[k-1];
                r_dst[k] <= r_dst[k-1];
            end
            r_fu[0] <= FRAC_BITS'(i_frac_u);
            r_fv[0] <= FRAC_BITS'(i_frac_v);
            for (int k = 1; k < PM_LAT; k++) begin
                r_fu[k] <= r_fu[k-1];
                r_fv[k] <= r_fv[k-1];
            end
            r_dpm[0] <= pm_dst;
            for (int k = 1; k < FLT_LAT; k++) begin
                r_dpm[k] <= r_dpm[k-1];
            end
            r_abyte[0] <= n_abyte;
            r_az[0]    <= az;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_abyte[k] <= r_abyte[k-1];
                r_az[k]    <= r_az[k-1];
            end
        end
    end

    always_comb begin
        if (!r_cov[SIDE_LAT-1]) begin
            n_pixel = r_dst[SIDE_LAT-1];
        end else if (r_az[DIV_LAT-1]) begin
            n_pixel = '0;
        end else begin
            n_pixel = {r_abyte[DIV_LAT-1], cbyte[2], cbyte[1], cbyte[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pixel   <= n_pixel;
            r_written <= r_cov[SIDE_LAT-1];
        end
    end

    assign o_valid       = r_vld[PIPE_LAT-1];
    assign o_pixel_out   = r_pixel;
    assign o_was_written = r_written;

    `TPBC_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid && i_stall, "Input stalled without a waiting result.")
    `TPBC_ASSERT_NEXT(a_hold_valid_bits, i_clk, i_rst_n, !adv, $stable(r_vld), "Valid bits moved during a stall.")
    `TPBC_ASSERT_NEXT(a_item_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "Accepted item lost at pipeline entry.")

endmodule
